// ===== src/zsbf_pkg.sv =====
// Shared types and constants for the zlib stored-block framer.
// Used by the front end, back end and top level; depends on nothing.
package zsbf_pkg;

   // zlib stream header and Adler-32 modulus
   localparam logic [7:0]  ZLIB_CMF   = 8'h78;
   localparam logic [7:0]  ZLIB_FLG   = 8'h01;
   localparam logic [16:0] ADLER_MOD  = 17'd65521;

   // CSR register index (byte address / 4)
   localparam logic        CSR_IDX_TOTAL_LENGTH = 1'b0;

   // configuration write toward the front end
   typedef struct packed {
      logic        wr;
      logic [31:0] value;
   } cfg_write_type;

   // classified request handed from front end to back end
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        overflow;
      logic        zlib_hdr;
      logic        blk_hdr;
      logic        blk_final;
      logic [15:0] chunk;
      logic        trailer;
      logic [15:0] adler_high;
      logic [15:0] adler_low;
   } cmd_type;

   // one result byte of the zlib stream
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
      logic       overflow;
   } rsp_type;

   // emission step of the back end
   typedef enum logic [3:0] {
      STEP_START,
      STEP_ZHDR0,
      STEP_ZHDR1,
      STEP_BFLAG,
      STEP_LEN0,
      STEP_LEN1,
      STEP_NLEN0,
      STEP_NLEN1,
      STEP_DATA,
      STEP_ADL0,
      STEP_ADL1,
      STEP_ADL2,
      STEP_ADL3,
      STEP_OVF
   } step_type;

endpackage

// ===== src/zsbf_fifo.sv =====
// Small register-based FIFO used for the command and result queues.
// Generic: no package dependency.
module zsbf_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== src/zsbf_front.sv =====
// Front end: accepts raw bytes, tracks stream/block position and Adler-32.
// Emits one classified command per byte. Depends on zsbf_pkg.
module zsbf_front import zsbf_pkg::*; #(
   parameter int unsigned STORED_BLOCK_MAX = 65535
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_write_type cfg,
   input  logic          accept,
   input  logic [7:0]    data_byte,
   output cmd_type       cmd
);

   localparam logic [31:0] MAX32 = 32'(STORED_BLOCK_MAX);
   localparam logic [15:0] MAX16 = 16'(STORED_BLOCK_MAX);

   logic [31:0] remain_ff, remain_in;      // total_length - bytes_taken
   logic        started_ff, started_in;    // bytes_taken != 0
   logic [15:0] blk_rem_ff, blk_rem_in;
   logic [15:0] low_ff, low_in;
   logic [15:0] high_ff, high_in;
   logic        finished_ff, finished_in;

   logic        final_blk;
   logic [15:0] chunk;
   logic [16:0] low_sum, high_sum;
   logic [15:0] low_new, high_new;

   // block sizing from bytes still to come
   assign final_blk = (remain_ff <= MAX32);
   assign chunk     = final_blk ? remain_ff[15:0] : MAX16;

   // Adler-32 sums, one conditional subtract each
   always_comb begin
      low_sum  = {1'b0, low_ff} + {9'd0, data_byte};
      low_new  = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
      high_sum = {1'b0, high_ff} + {1'b0, low_new};
      high_new = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];
   end

   // command build and state update
   always_comb begin
      cmd.data_byte  = data_byte;
      cmd.overflow   = finished_ff;
      cmd.zlib_hdr   = !started_ff;
      cmd.blk_hdr    = (blk_rem_ff == '0);
      cmd.blk_final  = final_blk;
      cmd.chunk      = chunk;
      cmd.trailer    = (remain_ff == 32'd1);
      cmd.adler_high = high_new;
      cmd.adler_low  = low_new;

      remain_in   = remain_ff;
      started_in  = started_ff;
      blk_rem_in  = blk_rem_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      finished_in = finished_ff;

      if (cfg.wr) begin
         remain_in   = cfg.value;
         started_in  = 1'b0;
         blk_rem_in  = '0;
         low_in      = 16'd1;
         high_in     = '0;
         finished_in = (cfg.value == '0);
      end else if (accept && !finished_ff) begin
         remain_in   = remain_ff - 32'd1;
         started_in  = 1'b1;
         blk_rem_in  = (cmd.blk_hdr ? chunk : blk_rem_ff) - 16'd1;
         low_in      = low_new;
         high_in     = high_new;
         finished_in = cmd.trailer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff   <= 32'd1;
         started_ff  <= 1'b0;
         blk_rem_ff  <= '0;
         low_ff      <= 16'd1;
         high_ff     <= '0;
         finished_ff <= 1'b0;
      end else begin
         remain_ff   <= remain_in;
         started_ff  <= started_in;
         blk_rem_ff  <= blk_rem_in;
         low_ff      <= low_in;
         high_ff     <= high_in;
         finished_ff <= finished_in;
      end
   end

   // nothing left to take means the stream is closed
   a_remain_zero_finished: assert property (@(posedge clock) disable iff (reset)
      (remain_ff == '0) |-> finished_ff)
      else $error("bytes remain exhausted but stream not finished");

   // overflow requests leave the state alone
   a_overflow_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (accept && finished_ff && !cfg.wr) |=> (finished_ff && $stable(remain_ff)))
      else $error("overflow request changed framing state");

endmodule

// ===== src/zsbf_back.sv =====
// Back end: expands each command into zlib stream bytes, one per cycle
// while the result queue has room. Depends on zsbf_pkg.
module zsbf_back import zsbf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    out_full,
   output logic    out_push,
   output rsp_type out_item
);

   step_type step_ff, step_in;
   step_type cur, nxt, first;
   logic     last;

   // first step for the command at the queue head
   always_comb begin
      if (cmd.overflow) begin
         first = STEP_OVF;
      end else if (cmd.zlib_hdr) begin
         first = STEP_ZHDR0;
      end else if (cmd.blk_hdr) begin
         first = STEP_BFLAG;
      end else begin
         first = STEP_DATA;
      end
   end

   // emission sequencer
   always_comb begin
      cur = (step_ff == STEP_START) ? first : step_ff;
      out_item.out_byte   = 8'd0;
      out_item.stream_end = 1'b0;
      out_item.overflow   = 1'b0;
      last = 1'b0;
      nxt  = STEP_START;
      case (cur)
         STEP_ZHDR0: begin
            out_item.out_byte = ZLIB_CMF;
            nxt = STEP_ZHDR1;
         end
         STEP_ZHDR1: begin
            out_item.out_byte = ZLIB_FLG;
            nxt = cmd.blk_hdr ? STEP_BFLAG : STEP_DATA;
         end
         STEP_BFLAG: begin
            out_item.out_byte = {7'd0, cmd.blk_final};
            nxt = STEP_LEN0;
         end
         STEP_LEN0: begin
            out_item.out_byte = cmd.chunk[7:0];
            nxt = STEP_LEN1;
         end
         STEP_LEN1: begin
            out_item.out_byte = cmd.chunk[15:8];
            nxt = STEP_NLEN0;
         end
         STEP_NLEN0: begin
            out_item.out_byte = ~cmd.chunk[7:0];
            nxt = STEP_NLEN1;
         end
         STEP_NLEN1: begin
            out_item.out_byte = ~cmd.chunk[15:8];
            nxt = STEP_DATA;
         end
         STEP_DATA: begin
            out_item.out_byte = cmd.data_byte;
            last = !cmd.trailer;
            nxt = STEP_ADL0;
         end
         STEP_ADL0: begin
            out_item.out_byte = cmd.adler_high[15:8];
            nxt = STEP_ADL1;
         end
         STEP_ADL1: begin
            out_item.out_byte = cmd.adler_high[7:0];
            nxt = STEP_ADL2;
         end
         STEP_ADL2: begin
            out_item.out_byte = cmd.adler_low[15:8];
            nxt = STEP_ADL3;
         end
         STEP_ADL3: begin
            out_item.out_byte   = cmd.adler_low[7:0];
            out_item.stream_end = 1'b1;
            last = 1'b1;
         end
         STEP_OVF: begin
            out_item.overflow = 1'b1;
            last = 1'b1;
         end
         default: begin
            last = 1'b1;
         end
      endcase
      out_item.run_last = last;

      out_push = cmd_valid && !out_full;
      cmd_pop  = out_push && last;
      step_in  = step_ff;
      if (out_push) begin
         step_in = last ? STEP_START : nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_START;
      end else begin
         step_ff <= step_in;
      end
   end

   // mid-sequence means the request is still at the queue head
   a_step_has_cmd: assert property (@(posedge clock) disable iff (reset)
      (step_ff != STEP_START) |-> cmd_valid)
      else $error("sequencer mid-request with empty command queue");

   // trailer end retires a request that carried the trailer
   a_end_retires: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_item.stream_end) |-> (cmd.trailer && cmd_pop))
      else $error("stream end emitted without retiring a trailer request");

endmodule

// ===== src/zlib_stored_block_framer_top.sv =====
// Top level of the zlib stored-block framer: CSR port, queues, front and back.
// Depends on zsbf_pkg, zsbf_fifo, zsbf_front, zsbf_back.
//
//  channel   ports                              handshake
//  -------   --------------------------------   -------------------------------
//  request   push, full, req_data_byte          accepted when push && !full
//  result    empty, pop, rsp_out_byte,          accepted when pop && !empty
//            rsp_run_last, rsp_stream_end,
//            rsp_overflow
//  csr       psel, penable, pwrite, paddr,      write at psel&penable&pwrite
//            pwdata, prdata, pready             (pready tied high)
//
// A request is classified combinationally and queued; a plain data byte gives
// one result, so the block sustains one request per cycle while full is low.
// The back end emits one result byte per cycle while out_full is low; the first
// request adds the zlib header, a block start its header, the last the trailer.
// Those bursts fill the command queue (CMD_DEPTH) before full is raised.
// Reset is synchronous; total_length returns to 1 and both queues empty.
// The result queue decouples pop stalls from the back end.
module zlib_stored_block_framer_top import zsbf_pkg::*; #(
   parameter int unsigned STORED_BLOCK_MAX = 65535,
   parameter int unsigned CMD_DEPTH        = 4,
   parameter int unsigned OUT_DEPTH        = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_stream_end,
   output logic        rsp_overflow,
   // csr port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [31:0]   total_length_ff, total_length_in;
   cfg_write_type cfg;
   logic          accept;
   cmd_type       cmd_wr, cmd_rd;
   logic          cmd_full, cmd_empty, cmd_pop;
   logic          out_push, out_full;
   rsp_type       out_wr, out_rd;

   // csr decode: one register at index 0
   assign pready    = 1'b1;
   assign cfg.wr    = psel && penable && pwrite && (paddr[2] == CSR_IDX_TOTAL_LENGTH);
   assign cfg.value = pwdata;
   assign prdata    = (paddr[2] == CSR_IDX_TOTAL_LENGTH) ? total_length_ff : 32'd0;
   assign total_length_in = cfg.wr ? pwdata : total_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_length_ff <= 32'd1;
      end else begin
         total_length_ff <= total_length_in;
      end
   end

   // request side
   assign full   = cmd_full;
   assign accept = push && !cmd_full;

   zsbf_front #(
      .STORED_BLOCK_MAX (STORED_BLOCK_MAX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .data_byte (req_data_byte),
      .cmd       (cmd_wr)
   );

   zsbf_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   zsbf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_wr)
   );

   zsbf_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_wr),
      .full    (out_full),
      .pop     (pop),
      .rd_data (out_rd),
      .empty   (empty)
   );

   // result ports
   assign rsp_out_byte   = out_rd.out_byte;
   assign rsp_run_last   = out_rd.run_last;
   assign rsp_stream_end = out_rd.stream_end;
   assign rsp_overflow   = out_rd.overflow;

endmodule
